>>> rtl/cpf_pkg.sv
package cpf_pkg;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [8:0]  COUNT_MAX = 9'd511;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One accepted input item, as it travels from the front to the back.
  typedef struct packed {
    logic        first;
    logic        last;
    logic        has_byte;
    logic [7:0]  msg_id;
    logic [15:0] seq_num;
    logic [7:0]  decl_len;
    logic [7:0]  data_byte;
  } cmd_t;

  // Which byte of the frame the back end emits next.
  typedef enum logic [2:0] {
    STEP_ID,
    STEP_SEQ_HI,
    STEP_SEQ_LO,
    STEP_LEN,
    STEP_DATA,
    STEP_CRC_HI,
    STEP_CRC_LO,
    STEP_DONE
  } step_e;

  // CRC-16/CCITT-FALSE update for one byte, MSB first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/cpf_front.sv
module cpf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          first_i,
  input  logic          last_i,
  input  logic          has_byte_i,
  input  logic [7:0]    msg_id_i,
  input  logic [15:0]   seq_num_i,
  input  logic [7:0]    decl_len_i,
  input  logic [7:0]    data_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output cpf_pkg::cmd_t push_cmd_o
);

  logic in_message_q, in_message_d;
  logic accept;
  logic useful;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Items outside a message, and items inside one that carry neither a byte nor the last flag, never reach the queue.
  assign useful = first_i || (in_message_q && (has_byte_i || last_i));
  assign push_o = accept && useful;

  assign push_cmd_o.first     = first_i;
  assign push_cmd_o.last      = last_i;
  assign push_cmd_o.has_byte  = has_byte_i;
  assign push_cmd_o.msg_id    = msg_id_i;
  assign push_cmd_o.seq_num   = seq_num_i;
  assign push_cmd_o.decl_len  = decl_len_i;
  assign push_cmd_o.data_byte = data_byte_i;

  always_comb begin
    in_message_d = in_message_q;
    if (accept) begin
      if (first_i) begin
        in_message_d = !last_i;
      end else if (last_i) begin
        in_message_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_message_q <= 1'b0;
    end else begin
      in_message_q <= in_message_d;
    end
  end

endmodule

>>> rtl/cpf_queue.sv
module cpf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cpf_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output cpf_pkg::cmd_t head_cmd_o
);

  localparam int unsigned PtrW = $clog2(cpf_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(cpf_pkg::QUEUE_DEPTH + 1);

  cpf_pkg::cmd_t       mem_q [cpf_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o       = (count_q == CntW'(cpf_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(cpf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(cpf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/cpf_back.sv
module cpf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  cpf_pkg::cmd_t head_cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          frame_end_o,
  output logic          length_error_o
);

  cpf_pkg::step_e step_q, step_d;
  cpf_pkg::step_e cur_step, next_step;
  logic           busy_q, busy_d;
  logic [15:0]    crc_q, crc_d;
  logic [8:0]     count_q, count_d;
  logic [7:0]     decl_q, decl_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           frame_end_q, frame_end_d;
  logic           length_error_q, length_error_d;
  logic           emit;
  logic [7:0]     sel_byte;
  logic [15:0]    crc_base;

  assign emit = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (busy_q) begin
      cur_step = step_q;
    end else if (head_cmd_i.first) begin
      cur_step = cpf_pkg::STEP_ID;
    end else if (head_cmd_i.has_byte) begin
      cur_step = cpf_pkg::STEP_DATA;
    end else begin
      cur_step = cpf_pkg::STEP_CRC_HI;
    end
  end

  always_comb begin
    next_step = cpf_pkg::STEP_DONE;
    case (cur_step)
      cpf_pkg::STEP_ID:     next_step = cpf_pkg::STEP_SEQ_HI;
      cpf_pkg::STEP_SEQ_HI: next_step = cpf_pkg::STEP_SEQ_LO;
      cpf_pkg::STEP_SEQ_LO: next_step = cpf_pkg::STEP_LEN;
      cpf_pkg::STEP_LEN: begin
        if (head_cmd_i.has_byte) begin
          next_step = cpf_pkg::STEP_DATA;
        end else if (head_cmd_i.last) begin
          next_step = cpf_pkg::STEP_CRC_HI;
        end
      end
      cpf_pkg::STEP_DATA: begin
        if (head_cmd_i.last) begin
          next_step = cpf_pkg::STEP_CRC_HI;
        end
      end
      cpf_pkg::STEP_CRC_HI: next_step = cpf_pkg::STEP_CRC_LO;
      default:              next_step = cpf_pkg::STEP_DONE;
    endcase
  end

  always_comb begin
    sel_byte = head_cmd_i.data_byte;
    case (cur_step)
      cpf_pkg::STEP_ID:     sel_byte = head_cmd_i.msg_id;
      cpf_pkg::STEP_SEQ_HI: sel_byte = head_cmd_i.seq_num[15:8];
      cpf_pkg::STEP_SEQ_LO: sel_byte = head_cmd_i.seq_num[7:0];
      cpf_pkg::STEP_LEN:    sel_byte = head_cmd_i.decl_len;
      cpf_pkg::STEP_CRC_HI: sel_byte = crc_q[15:8];
      cpf_pkg::STEP_CRC_LO: sel_byte = crc_q[7:0];
      default:              sel_byte = head_cmd_i.data_byte;
    endcase
  end

  // A new frame restarts the CRC from its initial value.
  assign crc_base = (cur_step == cpf_pkg::STEP_ID) ? cpf_pkg::CRC_INIT : crc_q;

  always_comb begin
    step_d         = step_q;
    busy_d         = busy_q;
    crc_d          = crc_q;
    count_d        = count_q;
    decl_d         = decl_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_byte_d     = out_byte_q;
    frame_end_d    = frame_end_q;
    length_error_d = length_error_q;
    pop_o          = 1'b0;
    if (emit) begin
      out_valid_d    = 1'b1;
      out_byte_d     = sel_byte;
      frame_end_d    = (cur_step == cpf_pkg::STEP_CRC_LO);
      length_error_d = (cur_step == cpf_pkg::STEP_CRC_LO) && (count_q != {1'b0, decl_q});
      case (cur_step)
        cpf_pkg::STEP_CRC_HI: begin
        end
        cpf_pkg::STEP_CRC_LO: begin
          crc_d   = cpf_pkg::CRC_INIT;
          count_d = '0;
        end
        default: begin
          crc_d = cpf_pkg::crc_feed(crc_base, sel_byte);
        end
      endcase
      if (cur_step == cpf_pkg::STEP_ID) begin
        count_d = '0;
        decl_d  = head_cmd_i.decl_len;
      end
      if ((cur_step == cpf_pkg::STEP_DATA) && (count_q != cpf_pkg::COUNT_MAX)) begin
        count_d = count_q + 9'd1;
      end
      if (next_step == cpf_pkg::STEP_DONE) begin
        pop_o  = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        step_d = next_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= cpf_pkg::STEP_ID;
      busy_q      <= 1'b0;
      crc_q       <= cpf_pkg::CRC_INIT;
      count_q     <= '0;
      decl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      crc_q       <= crc_d;
      count_q     <= count_d;
      decl_q      <= decl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q     <= out_byte_d;
    frame_end_q    <= frame_end_d;
    length_error_q <= length_error_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign frame_end_o    = frame_end_q;
  assign length_error_o = length_error_q;

`ifndef SYNTHESIS
  a_busy_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> head_valid_i)
    else $error("sequencer mid-item with an empty queue");

  a_err_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && length_error_o) |-> frame_end_o)
    else $error("length error flagged away from frame end");

  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_step == cpf_pkg::STEP_CRC_LO) |=>
      (crc_q == cpf_pkg::CRC_INIT && count_q == '0))
    else $error("CRC or count not restarted after frame end");

  a_decl_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cur_step == cpf_pkg::STEP_ID) |=> (decl_q == $past(head_cmd_i.decl_len)))
    else $error("declared length not captured at header start");
`endif

endmodule

>>> rtl/crc16_packet_framer.sv
// Chan Dir  Handshake                Beat fields
// in   in   in_valid_i / in_stall_o  first, last, has_byte, msg_id, seq_num, decl_len, data_byte
// out  out  out_valid_o / out_stall_i  out_byte, frame_end, length_error
//
// Each output beat is one frame byte; the back end produces at most one per cycle.
// A data item emits its byte; a start item emits ID, sequence high and low, length, then any
// data byte; a last item then adds the two CRC bytes, all that a bare closing item emits.
// The input is stalled only while the two-entry command queue is full.
// Reset is asynchronous and active low; it empties the queue, closes any message, sets the
// CRC to all ones and clears the byte count and the registered output valid.
module crc16_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_i,
  input  logic        last_i,
  input  logic        has_byte_i,
  input  logic [7:0]  msg_id_i,
  input  logic [15:0] seq_num_i,
  input  logic [7:0]  decl_len_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        length_error_o
);

  // Front end: tracks whether a message is open and drops items that emit nothing.
  logic          push;
  cpf_pkg::cmd_t push_cmd;
  logic          q_full;
  // Queue to back end.
  logic          pop;
  logic          head_valid;
  cpf_pkg::cmd_t head_cmd;

  cpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_i     (first_i),
    .last_i      (last_i),
    .has_byte_i  (has_byte_i),
    .msg_id_i    (msg_id_i),
    .seq_num_i   (seq_num_i),
    .decl_len_i  (decl_len_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  // The queue decouples input stalls from the byte-by-byte serialization.
  cpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // The back end walks each command through its frame bytes and keeps the running CRC.
  cpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_cmd_i     (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .length_error_o (length_error_o)
  );

endmodule
